// File: design/rpt_pkg.sv
// shared types, codes and constants for the rssi proximity tracker
package rpt_pkg;

    localparam int KIND_W  = 2;
    localparam int TIME_W  = 32;
    localparam int ADDR_W  = 48;
    localparam int LVL_W   = 8;
    localparam int STATE_W = 3;
    localparam int MS_W    = 22;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 22;

    localparam int DEF_WINDOW = 8;

    localparam logic [KIND_W-1:0] KIND_ADVERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FORGET = 2'd3;

    localparam logic [STATE_W-1:0] ST_UNPAIRED = 3'd0;
    localparam logic [STATE_W-1:0] ST_OUT      = 3'd1;
    localparam logic [STATE_W-1:0] ST_APPROACH = 3'd2;
    localparam logic [STATE_W-1:0] ST_NEAR     = 3'd3;
    localparam logic [STATE_W-1:0] ST_LEAVING  = 3'd4;

    localparam logic [CFG_IW-1:0] CFG_ENTER_THR   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RELEASE_THR = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DWELL       = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_RELEASE     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SAMPLE_STL  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ABS_STL     = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_NEAR_STL    = 3'd6;

    localparam logic signed [LVL_W-1:0] NO_LEVEL = -8'sd127;

    localparam logic signed [LVL_W-1:0] RST_ENTER_THR   = -8'sd65;
    localparam logic signed [LVL_W-1:0] RST_RELEASE_THR = -8'sd80;
    localparam logic [MS_W-1:0] RST_DWELL      = 22'd3000;
    localparam logic [MS_W-1:0] RST_RELEASE    = 22'd10000;
    localparam logic [MS_W-1:0] RST_SAMPLE_STL = 22'd3000;
    localparam logic [MS_W-1:0] RST_ABS_STL    = 22'd15000;
    localparam logic [MS_W-1:0] RST_NEAR_STL   = 22'd30000;

    typedef struct packed {
        logic capture;
        logic prep;
        logic sum_start;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic paired;
        logic fresh;
        logic ring_empty;
        logic sum_done;
        logic div_done;
    } t_dp_sts;

endpackage

// File: design/rpt_ctrl.sv
// sequencing state machine and result valid flag
module rpt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rpt_pkg::t_dp_cmd o_cmd,
    input  rpt_pkg::t_dp_sts i_sts
);
    import rpt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_fsm;
    logic [2:0] n_fsm;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_fsm = r_fsm;
        o_cmd = '0;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_fsm = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_fsm = (i_sts.is_tick && i_sts.paired) ? S_CHECK : S_FIN;
            end
            S_CHECK: begin
                if (i_sts.fresh && !i_sts.ring_empty) begin
                    o_cmd.sum_start = 1'b1;
                    n_fsm = S_SUM;
                end else begin
                    n_fsm = S_FIN;
                end
            end
            S_SUM: begin
                if (i_sts.sum_done) begin
                    o_cmd.div_start = 1'b1;
                    n_fsm = S_DIV;
                end else begin
                    o_cmd.sum_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_fsm = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_fsm = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_fsm != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/rpt_datapath.sv
// tracker state, sample ring, mean accumulator and divider, proximity decision
module rpt_datapath #(
    parameter int WINDOW = rpt_pkg::DEF_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rpt_pkg::t_dp_cmd                  i_cmd,
    output rpt_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_we,
    input  logic [rpt_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [rpt_pkg::CFG_DW-1:0]        i_cfg_data,
    input  logic [rpt_pkg::KIND_W-1:0]        i_kind,
    input  logic [rpt_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [rpt_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [rpt_pkg::LVL_W-1:0]  i_rssi,
    output logic [rpt_pkg::STATE_W-1:0]       o_prox_state,
    output logic signed [rpt_pkg::LVL_W-1:0]  o_smoothed_level,
    output logic                              o_state_changed,
    output logic                              o_sample_taken
);
    import rpt_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW  = CW + LVL_W;
    localparam int MW  = SW;
    localparam int DCW = $clog2(MW + 1);

    // configuration
    logic signed [LVL_W-1:0] r_enter_thr;
    logic signed [LVL_W-1:0] r_release_thr;
    logic [MS_W-1:0]         r_dwell;
    logic [MS_W-1:0]         r_release;
    logic [MS_W-1:0]         r_sample_stl;
    logic [MS_W-1:0]         r_abs_stl;
    logic [MS_W-1:0]         r_near_stl;

    // tracker state
    logic [STATE_W-1:0]      r_state, n_state;
    logic                    r_paired, n_paired;
    logic [ADDR_W-1:0]       r_peer, n_peer;
    logic [CW-1:0]           r_count, n_count;
    logic [PW-1:0]           r_wpos, n_wpos;
    logic [TIME_W-1:0]       r_last_time, n_last_time;
    logic [TIME_W-1:0]       r_entry_time, n_entry_time;
    logic signed [LVL_W-1:0] r_smooth, n_smooth;

    // captured request
    logic [KIND_W-1:0]       r_kind;
    logic [TIME_W-1:0]       r_now;
    logic [ADDR_W-1:0]       r_addr;
    logic signed [LVL_W-1:0] r_rssi;
    logic [TIME_W-1:0]       r_age;
    logic [TIME_W-1:0]       r_elapsed;

    // ring, accumulator, divider
    logic signed [LVL_W-1:0] r_ring [WINDOW];
    logic signed [LVL_W-1:0] r_rd_data;
    logic [CW-1:0]           r_idx;
    logic                    r_pend;
    logic signed [SW-1:0]    r_acc;
    logic [MW-1:0]           r_div;
    logic [CW-1:0]           r_rem;
    logic [DCW-1:0]          r_dcnt;

    logic                    issue;
    logic [CW:0]             shifted;
    logic                    qbit;
    logic                    fresh;
    logic                    take;
    logic                    changed;
    logic signed [LVL_W-1:0] mean;
    logic signed [LVL_W-1:0] tick_level;
    logic                    lvl_near;
    logic                    lvl_gone;
    logic                    age_abs;
    logic                    age_near;
    logic                    dwell_done;
    logic                    release_done;
    logic [STATE_W-1:0]      tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_thr   <= RST_ENTER_THR;
            r_release_thr <= RST_RELEASE_THR;
            r_dwell       <= RST_DWELL;
            r_release     <= RST_RELEASE;
            r_sample_stl  <= RST_SAMPLE_STL;
            r_abs_stl     <= RST_ABS_STL;
            r_near_stl    <= RST_NEAR_STL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENTER_THR:   r_enter_thr   <= i_cfg_data[LVL_W-1:0];
                CFG_RELEASE_THR: r_release_thr <= i_cfg_data[LVL_W-1:0];
                CFG_DWELL:       r_dwell       <= i_cfg_data[MS_W-1:0];
                CFG_RELEASE:     r_release     <= i_cfg_data[MS_W-1:0];
                CFG_SAMPLE_STL:  r_sample_stl  <= i_cfg_data[MS_W-1:0];
                CFG_ABS_STL:     r_abs_stl     <= i_cfg_data[MS_W-1:0];
                CFG_NEAR_STL:    r_near_stl    <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_now  <= i_now_ms;
            r_addr <= i_address;
            r_rssi <= i_rssi;
        end
        if (i_cmd.prep) begin
            r_age     <= r_now - r_last_time;
            r_elapsed <= r_now - r_entry_time;
        end
    end

    // mean: sequential sum over the ring, then restoring division of the magnitude
    assign issue   = (r_idx < r_count);
    assign shifted = {r_rem, r_div[MW-1]};
    assign qbit    = (shifted >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && take) begin
            r_ring[r_wpos] <= r_rssi;
        end
        if (i_cmd.sum_step && issue) begin
            r_rd_data <= r_ring[r_idx[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.sum_start) begin
            r_pend <= 1'b0;
        end else if (i_cmd.sum_step) begin
            r_pend <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_start) begin
            r_idx <= '0;
            r_acc <= '0;
        end else if (i_cmd.sum_step) begin
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_pend) begin
                r_acc <= r_acc + SW'(r_rd_data);
            end
        end
        if (i_cmd.div_start) begin
            r_div  <= MW'(~r_acc + SW'(1));
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= qbit ? CW'(shifted - {1'b0, r_count}) : shifted[CW-1:0];
            r_div  <= {r_div[MW-2:0], qbit};
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    assign mean       = LVL_W'(~r_div[LVL_W-1:0] + LVL_W'(1));
    assign fresh      = (r_age <= TIME_W'(r_sample_stl));
    assign tick_level = (fresh && (r_count != '0)) ? mean : NO_LEVEL;
    assign lvl_near   = (tick_level >= r_enter_thr);
    assign lvl_gone   = (tick_level < r_release_thr);
    assign age_abs    = (r_age > TIME_W'(r_abs_stl));
    assign age_near   = (r_age > TIME_W'(r_near_stl));
    assign dwell_done   = (r_elapsed >= TIME_W'(r_dwell));
    assign release_done = (r_elapsed >= TIME_W'(r_release));
    assign take = (r_kind == KIND_ADVERT) && r_paired && (r_addr == r_peer) && r_rssi[LVL_W-1];

    always_comb begin
        n_state      = r_state;
        n_paired     = r_paired;
        n_peer       = r_peer;
        n_count      = r_count;
        n_wpos       = r_wpos;
        n_last_time  = r_last_time;
        n_entry_time = r_entry_time;
        n_smooth     = r_smooth;
        tgt          = r_state;
        changed      = 1'b0;
        unique case (r_kind)
            KIND_ADVERT: begin
                if (take) begin
                    n_wpos = (r_wpos == PW'(WINDOW - 1)) ? '0 : r_wpos + PW'(1);
                    if (r_count != CW'(WINDOW)) begin
                        n_count = r_count + CW'(1);
                    end
                    n_last_time = r_now;
                end
            end
            KIND_TICK: begin
                if (!r_paired) begin
                    tgt = ST_UNPAIRED;
                end else begin
                    n_smooth = tick_level;
                    if (!fresh) begin
                        n_count = '0;
                        n_wpos  = '0;
                    end
                    unique case (r_state)
                        ST_UNPAIRED: tgt = ST_OUT;
                        ST_OUT: begin
                            if (fresh && lvl_near) begin
                                tgt = ST_APPROACH;
                            end
                        end
                        ST_APPROACH: begin
                            priority if (age_abs) begin
                                tgt = ST_OUT;
                            end else if (fresh && lvl_gone) begin
                                tgt = ST_OUT;
                            end else if (fresh && lvl_near && dwell_done) begin
                                tgt = ST_NEAR;
                            end
                        end
                        ST_NEAR: begin
                            if (age_near || (fresh && lvl_gone)) begin
                                tgt = ST_LEAVING;
                            end
                        end
                        ST_LEAVING: begin
                            priority if (fresh && lvl_near) begin
                                tgt = ST_NEAR;
                            end else if (release_done) begin
                                tgt = ST_OUT;
                            end
                        end
                        default: tgt = ST_UNPAIRED;
                    endcase
                end
                if (tgt != r_state) begin
                    n_state      = tgt;
                    n_entry_time = r_now;
                    changed      = 1'b1;
                end
            end
            KIND_PAIR: begin
                n_peer   = r_addr;
                n_paired = 1'b1;
                n_count  = '0;
                n_wpos   = '0;
            end
            KIND_FORGET: begin
                n_paired = 1'b0;
                n_count  = '0;
                n_wpos   = '0;
                n_state  = ST_UNPAIRED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_UNPAIRED;
            r_paired     <= 1'b0;
            r_peer       <= '0;
            r_count      <= '0;
            r_wpos       <= '0;
            r_last_time  <= '0;
            r_entry_time <= '0;
            r_smooth     <= NO_LEVEL;
        end else if (i_cmd.commit) begin
            r_state      <= n_state;
            r_paired     <= n_paired;
            r_peer       <= n_peer;
            r_count      <= n_count;
            r_wpos       <= n_wpos;
            r_last_time  <= n_last_time;
            r_entry_time <= n_entry_time;
            r_smooth     <= n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_prox_state     <= n_state;
            o_smoothed_level <= n_smooth;
            o_state_changed  <= changed;
            o_sample_taken   <= take;
        end
    end

    assign o_sts.is_tick    = (r_kind == KIND_TICK);
    assign o_sts.paired     = r_paired;
    assign o_sts.fresh      = fresh;
    assign o_sts.ring_empty = (r_count == '0);
    assign o_sts.sum_done   = (r_idx == r_count) && !r_pend;
    assign o_sts.div_done   = (r_dcnt == DCW'(MW));

endmodule

// File: design/rssi_proximity_tracker_top.sv
// top level of the rssi proximity tracker
// Follows one paired peer: adverts from the peer with negative rssi fill a ring
// of WINDOW samples, ticks recompute the smoothed level (ring mean truncated
// toward zero, or -127 when stale or empty) and step the five-state proximity
// machine, pair and forget set or clear the peer. Every request gives exactly
// one result. Adverts, pair, forget and ticks while unpaired go through the
// capture, prep and finish steps; a paired tick adds a check step, plus the
// sequential sum over the n stored samples (one ring read per cycle) and the
// one-bit-per-cycle divider when the ring is fresh and not empty. The finish
// step waits while the output is held off. One request is in work at a time
// and the next is accepted the cycle after a result is registered; the result
// register lets it be accepted while a result still waits to be taken.
module rssi_proximity_tracker_top #(
    parameter int WINDOW = rpt_pkg::DEF_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rpt_pkg::KIND_W-1:0]        i_kind,
    input  logic [rpt_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [rpt_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [rpt_pkg::LVL_W-1:0]  i_rssi,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rpt_pkg::STATE_W-1:0]       o_prox_state,
    output logic signed [rpt_pkg::LVL_W-1:0]  o_smoothed_level,
    output logic                              o_state_changed,
    output logic                              o_sample_taken,
    input  logic                              i_cfg_we,
    input  logic [rpt_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [rpt_pkg::CFG_DW-1:0]        i_cfg_data
);
    import rpt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rpt_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_now_ms         (i_now_ms),
        .i_address        (i_address),
        .i_rssi           (i_rssi),
        .o_prox_state     (o_prox_state),
        .o_smoothed_level (o_smoothed_level),
        .o_state_changed  (o_state_changed),
        .o_sample_taken   (o_sample_taken)
    );

endmodule

// File: tb/rpt_tracker_checker.sv
// checker for the rssi proximity tracker: predicts each result and compares it
module rpt_tracker_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [rpt_pkg::KIND_W-1:0]        i_kind,
    input  logic [rpt_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [rpt_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [rpt_pkg::LVL_W-1:0]  i_rssi,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [rpt_pkg::STATE_W-1:0]       i_prox_state,
    input  logic signed [rpt_pkg::LVL_W-1:0]  i_smoothed_level,
    input  logic                              i_state_changed,
    input  logic                              i_sample_taken,
    input  logic                              i_cfg_we,
    input  logic [rpt_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [rpt_pkg::CFG_DW-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    localparam int RING_IW = $clog2(DEF_WINDOW);

    typedef struct packed {
        logic [STATE_W-1:0]      prox_state;
        logic signed [LVL_W-1:0] level;
        logic                    changed;
        logic                    taken;
    } t_prox_report;

    t_prox_report expected_reports[$];
    t_prox_report want;

    logic signed [LVL_W-1:0] enter_thr;
    logic signed [LVL_W-1:0] release_thr;
    logic [MS_W-1:0]         dwell_ms;
    logic [MS_W-1:0]         release_ms;
    logic [MS_W-1:0]         fresh_limit_ms;
    logic [MS_W-1:0]         abs_stale_ms;
    logic [MS_W-1:0]         near_stale_ms;

    logic [STATE_W-1:0]      cur_state;
    logic                    paired;
    logic [ADDR_W-1:0]       peer_addr;
    logic signed [LVL_W-1:0] ring [DEF_WINDOW];
    int                      ring_fill;
    logic [RING_IW-1:0]      ring_pos;
    logic [TIME_W-1:0]       last_sample_ms;
    logic [TIME_W-1:0]       entry_ms;
    logic signed [LVL_W-1:0] level;

    function automatic logic go_to(input logic [STATE_W-1:0] nxt,
                                   input logic [TIME_W-1:0] now);
        if (cur_state == nxt) begin
            return 1'b0;
        end
        cur_state = nxt;
        entry_ms  = now;
        return 1'b1;
    endfunction

    function automatic t_prox_report step_tracker(input logic [KIND_W-1:0] kind,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic signed [LVL_W-1:0] rssi);
        t_prox_report      rep;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] held;
        logic              fresh;
        logic              changed;
        logic              taken;
        int                sum;
        int                idx;
        changed = 1'b0;
        taken   = 1'b0;
        case (kind)
            KIND_ADVERT: begin
                if (paired && addr == peer_addr && rssi < 0) begin
                    ring[ring_pos] = rssi;
                    ring_pos = (ring_pos == RING_IW'(DEF_WINDOW - 1)) ? '0
                                                                      : ring_pos + RING_IW'(1);
                    if (ring_fill < DEF_WINDOW) begin
                        ring_fill++;
                    end
                    last_sample_ms = now;
                    taken = 1'b1;
                end
            end
            KIND_TICK: begin
                if (!paired) begin
                    changed = go_to(ST_UNPAIRED, now);
                end else begin
                    age   = now - last_sample_ms;
                    held  = now - entry_ms;
                    fresh = age <= TIME_W'(fresh_limit_ms);
                    if (!fresh) begin
                        level     = NO_LEVEL;
                        ring_fill = 0;
                        ring_pos  = '0;
                    end else if (ring_fill == 0) begin
                        level = NO_LEVEL;
                    end else begin
                        sum = 0;
                        for (idx = 0; idx < ring_fill; idx++) begin
                            sum += ring[RING_IW'(idx)];
                        end
                        level = LVL_W'(sum / ring_fill);
                    end
                    case (cur_state)
                        ST_UNPAIRED: begin
                            changed = go_to(ST_OUT, now);
                        end
                        ST_OUT: begin
                            if (fresh && level >= enter_thr) begin
                                changed = go_to(ST_APPROACH, now);
                            end
                        end
                        ST_APPROACH: begin
                            if (age > TIME_W'(abs_stale_ms)) begin
                                changed = go_to(ST_OUT, now);
                            end else if (fresh && level < release_thr) begin
                                changed = go_to(ST_OUT, now);
                            end else if (fresh && level >= enter_thr &&
                                         held >= TIME_W'(dwell_ms)) begin
                                changed = go_to(ST_NEAR, now);
                            end
                        end
                        ST_NEAR: begin
                            if (age > TIME_W'(near_stale_ms) ||
                                (fresh && level < release_thr)) begin
                                changed = go_to(ST_LEAVING, now);
                            end
                        end
                        ST_LEAVING: begin
                            if (fresh && level >= enter_thr) begin
                                changed = go_to(ST_NEAR, now);
                            end else if (held >= TIME_W'(release_ms)) begin
                                changed = go_to(ST_OUT, now);
                            end
                        end
                        default: begin
                            changed = go_to(ST_UNPAIRED, now);
                        end
                    endcase
                end
            end
            KIND_PAIR: begin
                peer_addr = addr;
                paired    = 1'b1;
                ring_fill = 0;
                ring_pos  = '0;
            end
            default: begin
                paired    = 1'b0;
                ring_fill = 0;
                ring_pos  = '0;
                cur_state = ST_UNPAIRED;
            end
        endcase
        rep.prox_state = cur_state;
        rep.level      = level;
        rep.changed    = changed;
        rep.taken      = taken;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enter_thr      = RST_ENTER_THR;
            release_thr    = RST_RELEASE_THR;
            dwell_ms       = RST_DWELL;
            release_ms     = RST_RELEASE;
            fresh_limit_ms = RST_SAMPLE_STL;
            abs_stale_ms   = RST_ABS_STL;
            near_stale_ms  = RST_NEAR_STL;
            cur_state      = ST_UNPAIRED;
            paired         = 1'b0;
            peer_addr      = '0;
            ring_fill      = 0;
            ring_pos       = '0;
            last_sample_ms = '0;
            entry_ms       = '0;
            level          = NO_LEVEL;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENTER_THR:   enter_thr      = i_cfg_data[LVL_W-1:0];
                    CFG_RELEASE_THR: release_thr    = i_cfg_data[LVL_W-1:0];
                    CFG_DWELL:       dwell_ms       = i_cfg_data[MS_W-1:0];
                    CFG_RELEASE:     release_ms     = i_cfg_data[MS_W-1:0];
                    CFG_SAMPLE_STL:  fresh_limit_ms = i_cfg_data[MS_W-1:0];
                    CFG_ABS_STL:     abs_stale_ms   = i_cfg_data[MS_W-1:0];
                    CFG_NEAR_STL:    near_stale_ms  = i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("result arrived with no request pending");
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_prox_state !== want.prox_state) begin
                        $error("prox_state mismatch: expected %0d, actual %0d",
                               want.prox_state, i_prox_state);
                        o_fail_count++;
                    end
                    if (i_smoothed_level !== want.level) begin
                        $error("smoothed_level mismatch: expected %0d, actual %0d",
                               want.level, i_smoothed_level);
                        o_fail_count++;
                    end
                    if (i_state_changed !== want.changed) begin
                        $error("state_changed mismatch: expected %0d, actual %0d",
                               want.changed, i_state_changed);
                        o_fail_count++;
                    end
                    if (i_sample_taken !== want.taken) begin
                        $error("sample_taken mismatch: expected %0d, actual %0d",
                               want.taken, i_sample_taken);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_reports.push_back(step_tracker(i_kind, i_now_ms, i_address, i_rssi));
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// File: tb/rssi_proximity_tracker_top_tb.sv
// testbench top for the rssi proximity tracker: clock, reset, stimulus and verdict
module rssi_proximity_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 250;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [KIND_W-1:0]       kind;
    logic [TIME_W-1:0]       now_ms;
    logic [ADDR_W-1:0]       address;
    logic signed [LVL_W-1:0] rssi;
    logic                    out_valid;
    logic                    out_stall;
    logic [STATE_W-1:0]      prox_state;
    logic signed [LVL_W-1:0] smoothed_level;
    logic                    state_changed;
    logic                    sample_taken;
    logic                    cfg_we;
    logic [CFG_IW-1:0]       cfg_index;
    logic [CFG_DW-1:0]       cfg_data;
    int                      fail_count;
    int                      pending;

    logic                    idle_on;
    logic                    pressure_req;
    logic [TIME_W-1:0]       clock_ms;
    logic [ADDR_W-1:0]       peer;
    logic                    tb_paired;
    int                      cycle_count = 0;

    rssi_proximity_tracker_top uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_kind           (kind),
        .i_now_ms         (now_ms),
        .i_address        (address),
        .i_rssi           (rssi),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_prox_state     (prox_state),
        .o_smoothed_level (smoothed_level),
        .o_state_changed  (state_changed),
        .o_sample_taken   (sample_taken),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    rpt_tracker_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_kind           (kind),
        .i_now_ms         (now_ms),
        .i_address        (address),
        .i_rssi           (rssi),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_prox_state     (prox_state),
        .i_smoothed_level (smoothed_level),
        .i_state_changed  (state_changed),
        .i_sample_taken   (sample_taken),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver side: random stall bursts, one long hold-off on demand
    initial begin
        logic held_long;
        int   span;
        out_stall = 1'b0;
        held_long = 1'b0;
        @(negedge clk);
        forever begin
            if (pressure_req && !held_long) begin
                held_long = 1'b1;
                out_stall <= 1'b1;
                span = 400;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                span = $urandom_range(1, 19);
            end else begin
                out_stall <= 1'b0;
                span = $urandom_range(1, 40);
            end
            repeat (span) @(negedge clk);
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                input logic [ADDR_W-1:0] a, input logic signed [LVL_W-1:0] r);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        now_ms   <= t;
        address  <= a;
        rssi     <= r;
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic apply_setup(input logic [CFG_DW-1:0] enter_v, input logic [CFG_DW-1:0] rel_v,
                               input logic [CFG_DW-1:0] dwell_v, input logic [CFG_DW-1:0] relt_v,
                               input logic [CFG_DW-1:0] stale_v, input logic [CFG_DW-1:0] abs_v,
                               input logic [CFG_DW-1:0] near_v);
        cfg_write(CFG_ENTER_THR, enter_v);
        cfg_write(CFG_RELEASE_THR, rel_v);
        cfg_write(CFG_DWELL, dwell_v);
        cfg_write(CFG_RELEASE, relt_v);
        cfg_write(CFG_SAMPLE_STL, stale_v);
        cfg_write(CFG_ABS_STL, abs_v);
        cfg_write(CFG_NEAR_STL, near_v);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed traffic from the paired peer, some noise and re-pairing
    task automatic send_random_item(input logic [TIME_W-1:0] step_max, output logic counted);
        int                      pick;
        int                      sel;
        logic [KIND_W-1:0]       k;
        logic [ADDR_W-1:0]       a;
        logic signed [LVL_W-1:0] r;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (sel < 90) begin
            clock_ms += $urandom_range(0, step_max);
        end else if (sel < 98) begin
            clock_ms += $urandom_range(0, 8 * step_max);
        end else begin
            clock_ms = $urandom;
        end
        k       = KIND_TICK;
        a       = ADDR_W'({$urandom, $urandom});
        r       = LVL_W'($urandom);
        counted = 1'b1;
        if ((!tb_paired && pick < 30) || pick < 3) begin
            k = KIND_PAIR;
            if ($urandom_range(0, 3) == 0) begin
                peer = ADDR_W'({$urandom, $urandom});
            end
            a = peer;
            tb_paired = 1'b1;
        end else if (pick < 5) begin
            k = KIND_FORGET;
            tb_paired = 1'b0;
        end else if (pick < 50) begin
            k   = KIND_ADVERT;
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                a = peer;
                r = LVL_W'(-int'($urandom_range(1, 128)));
                counted = tb_paired;
            end else if (sel == 8) begin
                counted = 1'b0;
            end else begin
                a = peer;
                r = LVL_W'($urandom_range(0, 127));
                counted = 1'b0;
            end
        end
        send_request(k, clock_ms, a, r);
    endtask

    initial begin
        int                phase;
        int                served;
        logic              counted;
        logic [TIME_W-1:0] step_max;
        in_valid     = 1'b0;
        kind         = KIND_ADVERT;
        now_ms       = '0;
        address      = '0;
        rssi         = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ENTER_THR;
        cfg_data     = '0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        pressure_req = 1'b0;
        peer         = ADDR_ONES;
        tb_paired    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unpaired corner cases, then a walk through every state
        send_request(KIND_TICK, 32'd5, ADDR_ZERO, 8'sd0);
        send_request(KIND_ADVERT, 32'd6, ADDR_ONES, -8'sd50);
        send_request(KIND_FORGET, 32'd7, ADDR_ONES, 8'sd0);
        send_request(KIND_PAIR, 32'd10, ADDR_ONES, 8'sd0);
        send_request(KIND_TICK, 32'd20, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd30, ADDR_ONES, 8'sh80);
        send_request(KIND_ADVERT, 32'd31, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd32, ADDR_ONES, 8'sd127);
        send_request(KIND_ADVERT, 32'd33, ADDR_ZERO, -8'sd30);
        send_request(KIND_ADVERT, 32'd34, ADDR_ONES, -8'sd1);
        send_request(KIND_ADVERT, 32'd35, ADDR_ONES, -8'sd1);
        send_request(KIND_TICK, 32'd40, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd3050, ADDR_ONES, -8'sd20);
        send_request(KIND_TICK, 32'd3100, ADDR_ONES, 8'sd0);
        send_request(KIND_TICK, 32'd40000, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd40100, ADDR_ONES, -8'sd30);
        send_request(KIND_TICK, 32'd40200, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd40300, ADDR_ONES, -8'sd120);
        send_request(KIND_ADVERT, 32'd40310, ADDR_ONES, -8'sd120);
        send_request(KIND_TICK, 32'd40400, ADDR_ONES, 8'sd0);
        send_request(KIND_TICK, 32'd52000, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'd52100, ADDR_ONES, -8'sd10);
        send_request(KIND_TICK, 32'd52200, ADDR_ONES, 8'sd0);
        send_request(KIND_TICK, 32'd70000, ADDR_ONES, 8'sd0);
        send_request(KIND_ADVERT, 32'hFFFF_FFFF, ADDR_ONES, 8'sh80);
        send_request(KIND_TICK, 32'd0, ADDR_ONES, 8'sd0);
        send_request(KIND_FORGET, 32'd1, ADDR_ONES, 8'sd0);
        clock_ms = 32'd1;

        for (phase = 0; phase < PHASES; phase++) begin
            drain_block();
            idle_on = (phase != PHASES - 1);
            case (phase)
                0: begin
                    apply_setup(CFG_DW'(-65), CFG_DW'(-80), CFG_DW'(1000), CFG_DW'(3000),
                                CFG_DW'(2000), CFG_DW'(6000), CFG_DW'(8000));
                    step_max = TIME_W'(700);
                end
                1: begin
                    apply_setup(CFG_DW'(-128), CFG_DW'(-128), CFG_DW'(0), CFG_DW'(0),
                                CFG_DW'(0), CFG_DW'(0), CFG_DW'(0));
                    step_max = TIME_W'(3);
                end
                2: begin
                    apply_setup(CFG_DW'(0), CFG_DW'(0), 22'd3600000, 22'd3600000,
                                22'd3600000, 22'd3600000, 22'd3600000);
                    step_max = TIME_W'(300000);
                end
                4: begin
                    apply_setup(CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                                CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                                CFG_DW'($urandom));
                    step_max = TIME_W'($urandom_range(1000, 2000000));
                end
                5: begin
                    apply_setup(CFG_DW'(-128), CFG_DW'(0), CFG_DW'($urandom_range(0, 4000)),
                                CFG_DW'($urandom_range(0, 4000)),
                                CFG_DW'($urandom_range(0, 4000)),
                                CFG_DW'($urandom_range(0, 8000)),
                                CFG_DW'($urandom_range(0, 8000)));
                    step_max = TIME_W'(1000);
                end
                default: begin
                    apply_setup(CFG_DW'(-int'($urandom_range(0, 128))),
                                CFG_DW'(-int'($urandom_range(0, 128))),
                                CFG_DW'($urandom_range(0, 8000)),
                                CFG_DW'($urandom_range(0, 8000)),
                                CFG_DW'($urandom_range(0, 8000)),
                                CFG_DW'($urandom_range(0, 8000)),
                                CFG_DW'($urandom_range(0, 8000)));
                    step_max = TIME_W'(1500);
                end
            endcase
            served = 0;
            while (served < ITEMS_PER_PHASE) begin
                if (phase == 2 && served == 60) begin
                    pressure_req = 1'b1;
                end
                send_random_item(step_max, counted);
                served += int'(counted);
            end
        end
        drain_block();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
design/rpt_pkg.sv
design/rpt_ctrl.sv
design/rpt_datapath.sv
design/rssi_proximity_tracker_top.sv
tb/rpt_tracker_checker.sv
tb/rssi_proximity_tracker_top_tb.sv
